>>> rtl/bdpq_pkg.sv
// Shared types, constants and helper functions of the Bayer dither palette quantizer.
package bdpq_pkg;

    localparam logic [1:0] MODE_WEB = 2'd0;
    localparam logic [1:0] MODE_VGA = 2'd1;
    localparam logic [1:0] MODE_RGB = 2'd2;

    localparam logic MSIZE_EIGHT = 1'b0;
    localparam logic MSIZE_FOUR  = 1'b1;

    localparam logic [1:0] CFG_COLOR_MODE   = 2'd0;
    localparam logic [1:0] CFG_MATRIX_SIZE  = 2'd1;
    localparam logic [1:0] CFG_STRENGTH_PCT = 2'd2;

    localparam logic [1:0] RST_COLOR_MODE   = MODE_RGB;
    localparam logic       RST_MATRIX_SIZE  = MSIZE_FOUR;
    localparam logic [7:0] RST_STRENGTH_PCT = 8'd200;

    localparam int VGA_N = 16;

    // Reciprocal constants: n/100 = (n*5243)>>19 for n below 43690, and
    // floor(x/51) = (x*643)>>15 for x up to 280.
    localparam logic [28:0] RECIP_100 = 29'd5243;
    localparam logic [18:0] RECIP_51  = 19'd643;

    localparam logic [5:0] BAYER8 [64] = '{
         6'd0, 6'd48, 6'd12, 6'd60,  6'd3, 6'd51, 6'd15, 6'd63,
        6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31,
         6'd8, 6'd56,  6'd4, 6'd52, 6'd11, 6'd59,  6'd7, 6'd55,
        6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23,
         6'd2, 6'd50, 6'd14, 6'd62,  6'd1, 6'd49, 6'd13, 6'd61,
        6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29,
        6'd10, 6'd58,  6'd6, 6'd54,  6'd9, 6'd57,  6'd5, 6'd53,
        6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21
    };

    localparam logic [3:0] BAYER4 [16] = '{
         4'd0,  4'd8,  4'd2, 4'd10,
        4'd12,  4'd4, 4'd14,  4'd6,
         4'd3, 4'd11,  4'd1,  4'd9,
        4'd15,  4'd7, 4'd13,  4'd5
    };

    localparam logic [7:0] VGA_PAL [VGA_N][3] = '{
        '{8'd0,   8'd0,   8'd0},   '{8'd128, 8'd0,   8'd0},
        '{8'd0,   8'd128, 8'd0},   '{8'd128, 8'd128, 8'd0},
        '{8'd0,   8'd0,   8'd128}, '{8'd128, 8'd0,   8'd128},
        '{8'd0,   8'd128, 8'd128}, '{8'd192, 8'd192, 8'd192},
        '{8'd128, 8'd128, 8'd128}, '{8'd255, 8'd0,   8'd0},
        '{8'd0,   8'd255, 8'd0},   '{8'd255, 8'd255, 8'd0},
        '{8'd0,   8'd0,   8'd255}, '{8'd255, 8'd0,   8'd255},
        '{8'd0,   8'd255, 8'd255}, '{8'd255, 8'd255, 8'd255}
    };

    typedef struct packed {
        logic [1:0] color_mode;
        logic       matrix_size;
        logic [7:0] strength_pct;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix;

    function automatic logic [15:0] sq_diff(input logic [7:0] v, input logic [7:0] p);
        logic [7:0] d;
        d = (v >= p) ? (v - p) : (p - v);
        return 16'(d) * 16'(d);
    endfunction

    // Nearest web-safe level 0..5 for one channel; ties cannot occur with odd step 51.
    function automatic logic [2:0] web_level(input logic [7:0] v);
        logic [18:0] prod;
        prod = (19'(v) + 19'd25) * RECIP_51;
        return prod[17:15];
    endfunction

endpackage

>>> rtl/bayer_dither_palette_quantizer.sv
// An accepted pixel leaves on o_palette_index with o_valid after passing every register stage.
// Throughput: one pixel per cycle while busy is low; six register stages, three for dithering, three for search.
// The receiver cannot stall, so the pipeline always advances and busy stays low once it falls after reset.
// Reset (synchronous, active low) restores the register defaults and empties the pipeline;
// busy is high during reset and until the registered ready flag is set after it.
module bayer_dither_palette_quantizer
    import bdpq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [11:0] i_column,
    input  logic [11:0] i_line,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    output logic        o_valid,
    output logic [7:0]  o_palette_index
);

    t_cfg r_cfg;
    t_pix pix;
    logic r_ready;
    logic accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.color_mode   <= RST_COLOR_MODE;
            r_cfg.matrix_size  <= RST_MATRIX_SIZE;
            r_cfg.strength_pct <= RST_STRENGTH_PCT;
            r_ready            <= 1'b0;
        end else begin
            r_ready <= 1'b1;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_COLOR_MODE:   r_cfg.color_mode   <= i_cfg_data[1:0];
                    CFG_MATRIX_SIZE:  r_cfg.matrix_size  <= i_cfg_data[0];
                    CFG_STRENGTH_PCT: r_cfg.strength_pct <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign busy   = ~r_ready;
    assign accept = start & ~busy;

    bdpq_dither u_dither (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (accept),
        .i_red     (i_red),
        .i_green   (i_green),
        .i_blue    (i_blue),
        .i_col_lo  (i_column[2:0]),
        .i_line_lo (i_line[2:0]),
        .i_cfg     (r_cfg),
        .o_pix     (pix)
    );

    bdpq_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .i_cfg   (r_cfg),
        .o_valid (o_valid),
        .o_index (o_palette_index)
    );

    // Every accepted beat comes out on o_valid after passing the whole pipeline.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##5 o_valid)
        else $error("accepted beat did not emerge after six cycles");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 6))
        else $error("result strobe without an accepted beat");

    a_web_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_palette_index <= 8'd215))
        else $error("palette index beyond web-safe range");

    a_vga_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_cfg.color_mode == MODE_VGA) |-> (o_palette_index < 8'd16))
        else $error("VGA index out of range");

    a_rgb_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_cfg.color_mode != MODE_WEB && r_cfg.color_mode != MODE_VGA)
        |-> (o_palette_index < 8'd8))
        else $error("RGB 8 index out of range");

endmodule

>>> rtl/bdpq_dither.sv
// Dither front end: threshold lookup, strength scaling, divide by 100 and clamp.
module bdpq_dither
    import bdpq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic [2:0] i_col_lo,
    input  logic [2:0] i_line_lo,
    input  t_cfg       i_cfg,
    output t_pix       o_pix
);

    logic [5:0]         n_thresh;
    logic signed [15:0] n_prod;
    logic signed [15:0] r1_prod;
    logic [7:0]         r1_ch [3];
    logic               r1_valid;

    logic signed [16:0] r2_num [3];
    logic               r2_valid;

    logic [7:0]         r3_ch [3];
    logic               r3_valid;

    always_comb begin
        logic signed [6:0] off;
        if (i_cfg.matrix_size == MSIZE_EIGHT) begin
            n_thresh = BAYER8[{i_line_lo, i_col_lo}];
        end else begin
            n_thresh = {BAYER4[{i_line_lo[1:0], i_col_lo[1:0]}], 2'b00};
        end
        off    = $signed({1'b0, n_thresh}) - 7'sd32;
        n_prod = 16'(off) * $signed({8'd0, i_cfg.strength_pct});
    end

    always_ff @(posedge i_clk) begin
        r1_prod  <= n_prod;
        r1_ch[0] <= i_red;
        r1_ch[1] <= i_green;
        r1_ch[2] <= i_blue;
        for (int k = 0; k < 3; k++) begin
            r2_num[k] <= $signed(17'(r1_ch[k]) * 17'd100) + 17'(r1_prod);
        end
        for (int k = 0; k < 3; k++) begin
            logic [28:0] q_prod;
            logic [8:0]  q;
            q_prod = 29'(r2_num[k][15:0]) * RECIP_100;
            q      = q_prod[27:19];
            if (r2_num[k][16]) begin
                r3_ch[k] <= 8'd0;
            end else if (q[8]) begin
                r3_ch[k] <= 8'd255;
            end else begin
                r3_ch[k] <= q[7:0];
            end
        end
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    assign o_pix.valid = r3_valid;
    assign o_pix.red   = r3_ch[0];
    assign o_pix.green = r3_ch[1];
    assign o_pix.blue  = r3_ch[2];

endmodule

>>> rtl/bdpq_match.sv
// Nearest palette search: separable web-safe and RGB 8 picks, VGA 16 distance tree.
module bdpq_match
    import bdpq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_pix       i_pix,
    input  t_cfg       i_cfg,
    output logic       o_valid,
    output logic [7:0] o_index
);

    logic [17:0] r4_dist [VGA_N];
    logic [7:0]  r4_web;
    logic [2:0]  r4_rgb;
    logic        r4_valid;

    logic [17:0] r5_dist [4];
    logic [3:0]  r5_idx  [4];
    logic [7:0]  r5_web;
    logic [2:0]  r5_rgb;
    logic        r5_valid;

    logic [7:0]  r6_index;
    logic        r6_valid;

    always_ff @(posedge i_clk) begin
        logic [2:0]  lr;
        logic [2:0]  lg;
        logic [2:0]  lb;
        logic [17:0] bd;
        logic [3:0]  bi;
        lr = web_level(i_pix.red);
        lg = web_level(i_pix.green);
        lb = web_level(i_pix.blue);
        r4_web <= 8'(lr) * 8'd36 + 8'(lg) * 8'd6 + 8'(lb);
        r4_rgb <= {i_pix.red[7], i_pix.green[7], i_pix.blue[7]};
        for (int k = 0; k < VGA_N; k++) begin
            r4_dist[k] <= 18'(sq_diff(i_pix.red,   VGA_PAL[k][0]))
                        + 18'(sq_diff(i_pix.green, VGA_PAL[k][1]))
                        + 18'(sq_diff(i_pix.blue,  VGA_PAL[k][2]));
        end

        // Each group of four keeps the first minimum, so ties go to the lower index.
        for (int g = 0; g < 4; g++) begin
            bd = r4_dist[4 * g];
            bi = 4'(4 * g);
            for (int j = 1; j < 4; j++) begin
                if (r4_dist[4 * g + j] < bd) begin
                    bd = r4_dist[4 * g + j];
                    bi = 4'(4 * g + j);
                end
            end
            r5_dist[g] <= bd;
            r5_idx[g]  <= bi;
        end
        r5_web <= r4_web;
        r5_rgb <= r4_rgb;

        bd = r5_dist[0];
        bi = r5_idx[0];
        for (int g = 1; g < 4; g++) begin
            if (r5_dist[g] < bd) begin
                bd = r5_dist[g];
                bi = r5_idx[g];
            end
        end
        case (i_cfg.color_mode)
            MODE_WEB: r6_index <= r5_web;
            MODE_VGA: r6_index <= 8'(bi);
            default:  r6_index <= 8'(r5_rgb);
        endcase

        if (!i_rst_n) begin
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else begin
            r4_valid <= i_pix.valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
        end
    end

    assign o_valid = r6_valid;
    assign o_index = r6_index;

endmodule
